### sv/itl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the impedance torque limiter
package itl_pkg;

	// fixed point layout
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned MAG_W = 33;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned ACC_W = 66;
	localparam int unsigned T_LSB = FRAC_W;
	localparam int unsigned T_MSB = FRAC_W + 31;
	localparam int unsigned SCALE_W = 17;
	localparam int unsigned QUOT_W = 16;
	localparam int unsigned DIV_CNT_W = 5;
	localparam int unsigned MASK_W = 16;
	localparam int unsigned SLOT_W = 4;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;
	localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;
	localparam logic [7:0] MOTOR_ENABLED = 8'd1;

	// result error codes
	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_MOTOR_OFF = 2'd1,
		ERR_OVERFLOW  = 2'd2,
		ERR_JOINTS    = 2'd3
	} itl_err_t;

	// multiply-accumulate operations
	typedef enum logic [1:0] {
		MAC_NOP  = 2'd0,
		MAC_LOAD = 2'd1,
		MAC_ACC  = 2'd2,
		MAC_MUL  = 2'd3
	} itl_mac_op_t;

	typedef struct packed {
		itl_mac_op_t op;
		logic        neg;
		logic        sh;
	} itl_mac_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} itl_div_stat_t;

endpackage

### sv/itl_if.sv
`timescale 1ns / 1ps
// channel interfaces of the impedance torque limiter

interface itl_cmd_if;
	logic               valid;
	logic               ready;
	logic [30:0]        joint_torque_limit;
	logic signed [31:0] pos_target;
	logic signed [31:0] vel_target;
	logic [30:0]        stiffness;
	logic [30:0]        damping;
	logic signed [31:0] ff_torque;
	logic signed [31:0] measured_position;
	logic signed [31:0] measured_velocity;
	logic [7:0]         motor_status;
	logic               degraded;
	logic               last_joint;

	modport source (
		output valid, joint_torque_limit, pos_target, vel_target, stiffness,
			damping, ff_torque, measured_position, measured_velocity,
			motor_status, degraded, last_joint,
		input ready
	);
	modport sink (
		input valid, joint_torque_limit, pos_target, vel_target, stiffness,
			damping, ff_torque, measured_position, measured_velocity,
			motor_status, degraded, last_joint,
		output ready
	);
endinterface

interface itl_res_if;
	logic               valid;
	logic               ready;
	logic [30:0]        stiffness_out;
	logic [30:0]        damping_out;
	logic signed [31:0] feedforward_out;
	logic signed [31:0] req_torque;
	logic signed [31:0] applied_torque;
	logic [16:0]        gain_scale;
	logic               torque_limited;
	logic [3:0]         joint_slot;
	logic [1:0]         error_code;
	logic [15:0]        limited_mask;
	logic [31:0]        act_count;
	logic               cycle_end;

	modport source (
		output valid, stiffness_out, damping_out, feedforward_out, req_torque,
			applied_torque, gain_scale, torque_limited, joint_slot, error_code,
			limited_mask, act_count, cycle_end,
		input ready
	);
	modport sink (
		input valid, stiffness_out, damping_out, feedforward_out, req_torque,
			applied_torque, gain_scale, torque_limited, joint_slot, error_code,
			limited_mask, act_count, cycle_end,
		output ready
	);
endinterface

interface itl_cfg_if;
	logic valid;
	logic ready;
	logic limiter_enabled;

	modport source (output valid, limiter_enabled, input ready);
	modport sink (input valid, limiter_enabled, output ready);
endinterface

### sv/itl_mac.sv
`timescale 1ns / 1ps
// shared 33x17 multiply-accumulate unit with a signed 66-bit accumulator
module itl_mac import itl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  itl_mac_ctl_t       ctl,
	input  logic [MAG_W-1:0]   op_a,
	input  logic [MUL_B_W-1:0] op_b,
	input  logic [ACC_W-1:0]   load_val,
	output logic [ACC_W-1:0]   acc
);

	logic [MAG_W+MUL_B_W-1:0] prod;
	logic [ACC_W-1:0]         term_u;
	logic [ACC_W-1:0]         term_sh;
	logic [ACC_W-1:0]         term_s;
	logic [ACC_W-1:0]         acc_q;

	// product, optional upper-half shift, optional negation
	always_comb begin
		prod    = op_a * op_b;
		term_u  = ACC_W'(prod);
		term_sh = ctl.sh ? (term_u << FRAC_W) : term_u;
		term_s  = ctl.neg ? (~term_sh + ACC_W'(1)) : term_sh;
	end

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			unique case (ctl.op)
				MAC_NOP:  acc_q <= acc_q;
				MAC_LOAD: acc_q <= load_val;
				MAC_ACC:  acc_q <= acc_q + term_s;
				MAC_MUL:  acc_q <= term_s;
				default:  acc_q <= acc_q;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

### sv/itl_div.sv
`timescale 1ns / 1ps
// radix-2 restoring divider for the Q0.16 scale, one quotient bit per cycle
module itl_div import itl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [30:0]       num,
	input  logic [31:0]       den,
	output itl_div_stat_t     stat,
	output logic [QUOT_W-1:0] quot
);

	logic [32:0]          rem_q;
	logic [31:0]          den_q;
	logic [QUOT_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [32:0]          rem_x2;
	logic                 ge;

	// one trial subtraction
	always_comb begin
		rem_x2 = {rem_q[31:0], 1'b0};
		ge     = (rem_x2 >= {1'b0, den_q});
	end

	// iteration control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= {2'b0, num};
				den_q  <= den;
				quo_q  <= '0;
				cnt_q  <= DIV_CNT_W'(QUOT_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? (rem_x2 - {1'b0, den_q}) : rem_x2;
				quo_q <= {quo_q[QUOT_W-2:0], ge};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quo_q;

endmodule

### sv/impedance_torque_limiter_core.sv
`timescale 1ns / 1ps
// Impedance torque limiter: forms kp*(pt-p)+kd*(vt-v)+ff in Q16.16 for one joint per
// transaction, scales gains by limit/|torque| when the (optionally quartered) limit is
// exceeded, and tracks the joint slot, limited-joint mask and activation count per control
// cycle. One joint is worked at a time: a joint past the joint count, one whose motor is not
// enabled, or one that arrives with the limiter disabled goes straight to hand-off, an
// unlimited or overflowing joint passes the gain products and range check, and a limited one
// also passes the divider and scaled outputs. The shared 33x17 multiply-accumulate unit takes
// two passes per gain product and one per scaled output; the 16-step divider forms the
// scale. The result sits in an output register, so the next joint is taken while the
// previous result waits; a joint finished while that register is still full waits for it.
module impedance_torque_limiter_core import itl_pkg::*; #(
	parameter int unsigned MAX_JOINTS = 16
) (
	input logic      clk,
	input logic      arst_n,
	itl_cfg_if.sink  cfg,
	itl_cmd_if.sink  cmd,
	itl_res_if.source res
);

	localparam int unsigned CNT_W = $clog2(MAX_JOINTS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOINTS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MP_LO,
		S_MP_HI,
		S_MD_LO,
		S_MD_HI,
		S_CHK,
		S_DIV,
		S_SC_KP,
		S_SC_KD,
		S_SC_FF,
		S_SC_T,
		S_SC_END,
		S_DONE
	} state_t;

	state_t state_q;

	// configuration and per-cycle bookkeeping
	logic              enabled_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MASK_W-1:0] cycle_mask_q;
	logic [31:0]       act_q;
	logic              failed_q;

	// working registers of the current joint
	logic [30:0]  lim_q;
	logic [30:0]  kp_q;
	logic [30:0]  kd_q;
	logic [31:0]  ff_q;
	logic [32:0]  dp_q;
	logic [32:0]  dv_q;
	logic         last_q;
	logic [31:0]  mag_q;
	logic         t_neg_q;
	logic [30:0]  kp_o_q;
	logic [30:0]  kd_o_q;
	logic [31:0]  ff_o_q;
	logic [31:0]  req_q;
	logic [31:0]  app_q;
	logic [SCALE_W-1:0] scale_q;
	logic         limited_q;
	itl_err_t     err_q;

	// result register
	logic               res_valid_q;
	logic [30:0]        res_kp_q;
	logic [30:0]        res_kd_q;
	logic [31:0]        res_ff_q;
	logic [31:0]        res_req_q;
	logic [31:0]        res_app_q;
	logic [SCALE_W-1:0] res_scale_q;
	logic               res_limited_q;
	logic [SLOT_W-1:0]  res_slot_q;
	itl_err_t           res_err_q;
	logic [MASK_W-1:0]  res_mask_q;
	logic [31:0]        res_act_q;
	logic               res_end_q;

	// shared units
	itl_mac_ctl_t       mac_ctl;
	logic [MAG_W-1:0]   mac_a;
	logic [MUL_B_W-1:0] mac_b;
	logic [ACC_W-1:0]   mac_load;
	logic [ACC_W-1:0]   acc;
	logic               div_start;
	itl_div_stat_t      div_stat;
	logic [QUOT_W-1:0]  div_quot;

	// combinational helpers
	logic               accept;
	logic               res_free;
	logic [CNT_W+3:0]   cnt_ext;
	logic [32:0]        dp_mag;
	logic [32:0]        dv_mag;
	logic [32:0]        ff_mag;
	logic [31:0]        t_w;
	logic [31:0]        t_mag;
	logic               t_ovf;
	logic [31:0]        acc_res;
	logic [MASK_W-1:0]  mask_nxt;
	logic               failed_nxt;
	logic [31:0]        act_nxt;

	assign accept   = cmd.valid && cmd.ready;
	assign res_free = !res_valid_q || res.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// magnitudes, resultant extraction and bookkeeping update
	always_comb begin
		cnt_ext = {4'b0, cnt_q};
		dp_mag  = dp_q[32] ? (~dp_q + 33'd1) : dp_q;
		dv_mag  = dv_q[32] ? (~dv_q + 33'd1) : dv_q;
		ff_mag  = ff_q[31] ? (~{1'b1, ff_q} + 33'd1) : {1'b0, ff_q};
		t_w     = acc[T_MSB:T_LSB];
		t_mag   = t_w[31] ? (~t_w + 32'd1) : t_w;
		t_ovf   = !((&acc[ACC_W-1:T_MSB]) || !(|acc[ACC_W-1:T_MSB]));
		acc_res = acc[T_MSB:T_LSB];
		mask_nxt = cycle_mask_q;
		if (limited_q && (cnt_ext < (CNT_W+4)'(MASK_W))) begin
			mask_nxt = cycle_mask_q | (MASK_W'(1) << cnt_ext[SLOT_W-1:0]);
		end
		failed_nxt = failed_q || (err_q != ERR_OK);
		act_nxt = act_q;
		if (last_q && !failed_nxt && (mask_nxt != '0)) begin
			act_nxt = act_q + 32'd1;
		end
	end

	// shared unit control
	always_comb begin
		mac_ctl   = '{op: MAC_NOP, neg: 1'b0, sh: 1'b0};
		mac_a     = '0;
		mac_b     = '0;
		mac_load  = {{(ACC_W-32-FRAC_W){cmd.ff_torque[31]}},
			cmd.ff_torque, ROUND_HALF};
		div_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) mac_ctl.op = MAC_LOAD;
			end
			S_MP_LO: begin
				mac_ctl = '{op: MAC_ACC, neg: dp_q[32], sh: 1'b0};
				mac_a   = dp_mag;
				mac_b   = {1'b0, kp_q[15:0]};
			end
			S_MP_HI: begin
				mac_ctl = '{op: MAC_ACC, neg: dp_q[32], sh: 1'b1};
				mac_a   = dp_mag;
				mac_b   = {2'b0, kp_q[30:16]};
			end
			S_MD_LO: begin
				mac_ctl = '{op: MAC_ACC, neg: dv_q[32], sh: 1'b0};
				mac_a   = dv_mag;
				mac_b   = {1'b0, kd_q[15:0]};
			end
			S_MD_HI: begin
				mac_ctl = '{op: MAC_ACC, neg: dv_q[32], sh: 1'b1};
				mac_a   = dv_mag;
				mac_b   = {2'b0, kd_q[30:16]};
			end
			S_CHK: begin
				div_start = !t_ovf && (t_mag > {1'b0, lim_q});
			end
			S_SC_KP: begin
				mac_ctl.op = MAC_MUL;
				mac_a      = {2'b0, kp_q};
				mac_b      = scale_q;
			end
			S_SC_KD: begin
				mac_ctl.op = MAC_MUL;
				mac_a      = {2'b0, kd_q};
				mac_b      = scale_q;
			end
			S_SC_FF: begin
				mac_ctl.op = MAC_MUL;
				mac_a      = ff_mag;
				mac_b      = scale_q;
			end
			S_SC_T: begin
				mac_ctl.op = MAC_MUL;
				mac_a      = {1'b0, mag_q};
				mac_b      = scale_q;
			end
			S_DIV, S_SC_END, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	itl_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mac_ctl),
		.op_a     (mac_a),
		.op_b     (mac_b),
		.load_val (mac_load),
		.acc      (acc)
	);

	itl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (lim_q),
		.den    (t_mag),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// sequencer, bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			enabled_q     <= 1'b1;
			cnt_q         <= '0;
			cycle_mask_q  <= '0;
			act_q         <= '0;
			failed_q      <= 1'b0;
			lim_q         <= '0;
			kp_q          <= '0;
			kd_q          <= '0;
			ff_q          <= '0;
			dp_q          <= '0;
			dv_q          <= '0;
			last_q        <= 1'b0;
			mag_q         <= '0;
			t_neg_q       <= 1'b0;
			kp_o_q        <= '0;
			kd_o_q        <= '0;
			ff_o_q        <= '0;
			req_q         <= '0;
			app_q         <= '0;
			scale_q       <= SCALE_ONE;
			limited_q     <= 1'b0;
			err_q         <= ERR_OK;
			res_valid_q   <= 1'b0;
			res_kp_q      <= '0;
			res_kd_q      <= '0;
			res_ff_q      <= '0;
			res_req_q     <= '0;
			res_app_q     <= '0;
			res_scale_q   <= SCALE_ONE;
			res_limited_q <= 1'b0;
			res_slot_q    <= '0;
			res_err_q     <= ERR_OK;
			res_mask_q    <= '0;
			res_act_q     <= '0;
			res_end_q     <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				enabled_q <= cfg.limiter_enabled;
			end
			// result taken while no new one is handed over
			if (res_valid_q && res.ready && (state_q != S_DONE)) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				// capture the joint and settle the early checks
				S_IDLE: begin
					if (accept) begin
						lim_q   <= cmd.degraded ? {2'b0, cmd.joint_torque_limit[30:2]}
							: cmd.joint_torque_limit;
						kp_q    <= cmd.stiffness;
						kd_q    <= cmd.damping;
						ff_q    <= cmd.ff_torque;
						dp_q    <= {cmd.pos_target[31], cmd.pos_target}
							- {cmd.measured_position[31], cmd.measured_position};
						dv_q    <= {cmd.vel_target[31], cmd.vel_target}
							- {cmd.measured_velocity[31], cmd.measured_velocity};
						last_q  <= cmd.last_joint;
						kp_o_q  <= cmd.stiffness;
						kd_o_q  <= cmd.damping;
						ff_o_q  <= cmd.ff_torque;
						req_q   <= '0;
						app_q   <= '0;
						scale_q <= SCALE_ONE;
						limited_q <= 1'b0;
						priority if (cnt_q >= MAX_CNT) begin
							err_q   <= ERR_JOINTS;
							state_q <= S_DONE;
						end else if (!enabled_q) begin
							err_q   <= ERR_OK;
							state_q <= S_DONE;
						end else if (cmd.motor_status != MOTOR_ENABLED) begin
							err_q   <= ERR_MOTOR_OFF;
							state_q <= S_DONE;
						end else begin
							err_q   <= ERR_OK;
							state_q <= S_MP_LO;
						end
					end
				end
				S_MP_LO: state_q <= S_MP_HI;
				S_MP_HI: state_q <= S_MD_LO;
				S_MD_LO: state_q <= S_MD_HI;
				S_MD_HI: state_q <= S_CHK;
				// range check and limit compare on the rounded resultant
				S_CHK: begin
					if (t_ovf) begin
						err_q   <= ERR_OVERFLOW;
						state_q <= S_DONE;
					end else begin
						req_q   <= t_w;
						app_q   <= t_w;
						mag_q   <= t_mag;
						t_neg_q <= t_w[31];
						state_q <= div_start ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (div_stat.done) begin
						scale_q <= {1'b0, div_quot};
						state_q <= S_SC_KP;
					end
				end
				S_SC_KP: state_q <= S_SC_KD;
				S_SC_KD: begin
					kp_o_q  <= acc_res[30:0];
					state_q <= S_SC_FF;
				end
				S_SC_FF: begin
					kd_o_q  <= acc_res[30:0];
					state_q <= S_SC_T;
				end
				S_SC_T: begin
					ff_o_q  <= ff_q[31] ? (~acc_res + 32'd1) : acc_res;
					state_q <= S_SC_END;
				end
				S_SC_END: begin
					app_q     <= t_neg_q ? (~acc_res + 32'd1) : acc_res;
					limited_q <= 1'b1;
					state_q   <= S_DONE;
				end
				// hand the result over and advance the cycle bookkeeping
				S_DONE: begin
					if (res_free) begin
						res_valid_q   <= 1'b1;
						res_kp_q      <= kp_o_q;
						res_kd_q      <= kd_o_q;
						res_ff_q      <= ff_o_q;
						res_req_q     <= req_q;
						res_app_q     <= app_q;
						res_scale_q   <= scale_q;
						res_limited_q <= limited_q;
						res_slot_q    <= cnt_ext[SLOT_W-1:0];
						res_err_q     <= err_q;
						res_mask_q    <= mask_nxt;
						res_act_q     <= act_nxt;
						res_end_q     <= last_q;
						act_q         <= act_nxt;
						if (last_q) begin
							cnt_q        <= '0;
							cycle_mask_q <= '0;
							failed_q     <= 1'b0;
						end else begin
							cycle_mask_q <= mask_nxt;
							failed_q     <= failed_nxt;
							if (cnt_q < MAX_CNT) cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result port
	assign res.valid            = res_valid_q;
	assign res.stiffness_out    = res_kp_q;
	assign res.damping_out      = res_kd_q;
	assign res.feedforward_out  = res_ff_q;
	assign res.req_torque       = res_req_q;
	assign res.applied_torque   = res_app_q;
	assign res.gain_scale       = res_scale_q;
	assign res.torque_limited   = res_limited_q;
	assign res.joint_slot       = res_slot_q;
	assign res.error_code       = res_err_q;
	assign res.limited_mask     = res_mask_q;
	assign res.act_count        = res_act_q;
	assign res.cycle_end        = res_end_q;

	// a limited joint always carries a scale below one
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.torque_limited |-> res.gain_scale < SCALE_ONE)
		else $error("limited result with full scale");

	// an errored joint is never limited and keeps unit scale
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res_err_q != ERR_OK) |-> !res.torque_limited
			&& res.gain_scale == SCALE_ONE)
		else $error("errored result carries limiting");

	// the divider is only started when idle
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// the joint counter saturates at the joint count
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("joint counter beyond limit");

	// a new joint never arrives while the divider still runs
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !div_stat.busy && !div_stat.done)
		else $error("joint accepted during division");

endmodule

### bench/itl_limiter_checker.sv
`timescale 1ns / 1ps
// transaction checker: predicts each joint result of the torque limiter and compares it
module itl_limiter_checker import itl_pkg::*; #(
	parameter int unsigned MAX_JOINTS = 16
) (
	input logic clk,
	input logic arst_n,
	itl_cfg_if  cfg,
	itl_cmd_if  cmd,
	itl_res_if  res,
	output int  fails,
	output int  pending
);

	localparam longint TORQUE_MAX = 64'sd2147483647;
	localparam longint TORQUE_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [30:0]        lim_in;
		logic signed [31:0] pos_target;
		logic signed [31:0] vel_target;
		logic [30:0]        stiffness;
		logic [30:0]        damping;
		logic signed [31:0] feedforward;
		logic signed [31:0] measured_position;
		logic signed [31:0] measured_velocity;
		logic [7:0]         motor_status;
		logic               degraded;
		logic               last_joint;
	} joint_cmd_t;

	typedef struct packed {
		logic [30:0]        stiffness;
		logic [30:0]        damping;
		logic [31:0]        feedforward;
		logic [31:0]        requested;
		logic [31:0]        applied;
		logic [SCALE_W-1:0] scale;
		logic               limited;
		logic [SLOT_W-1:0]  slot;
		itl_err_t           err;
		logic [MASK_W-1:0]  mask;
		logic [31:0]        activations;
		logic               cycle_end;
	} joint_result_t;

	// mirror of the block's configuration and per-cycle state
	bit                limiter_on = 1'b1;
	int                seen_joints = 0;
	logic [MASK_W-1:0] cycle_mask = '0;
	logic [31:0]       activations = '0;
	bit                cycle_error = 1'b0;
	joint_result_t     expected_results[$];

	// magnitude times a Q0.16 scale, truncated toward zero
	function automatic longint scale_toward_zero(longint v, longint s);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m * s) >>> FRAC_W;
		return (v < 0) ? -m : m;
	endfunction

	// expected result of one joint; advances the cycle state
	function automatic joint_result_t predict_joint(joint_cmd_t c);
		joint_result_t r;
		longint pos_term, vel_term, frac_sum, torque, mag, lim, scale;
		r.stiffness = c.stiffness;
		r.damping = c.damping;
		r.feedforward = c.feedforward;
		r.requested = '0;
		r.applied = '0;
		r.scale = SCALE_ONE;
		r.limited = 1'b0;
		r.slot = SLOT_W'(seen_joints);
		r.err = ERR_OK;
		if (seen_joints >= MAX_JOINTS) begin
			r.err = ERR_JOINTS;
		end else if (limiter_on) begin
			if (c.motor_status != MOTOR_ENABLED) begin
				r.err = ERR_MOTOR_OFF;
			end else begin
				// exact products, one rounding to Q16.16, ties toward plus infinity
				pos_term = longint'(c.stiffness) *
					(longint'(c.pos_target) - longint'(c.measured_position));
				vel_term = longint'(c.damping) *
					(longint'(c.vel_target) - longint'(c.measured_velocity));
				frac_sum = (pos_term & 64'hFFFF) + (vel_term & 64'hFFFF);
				torque = (pos_term >>> FRAC_W) + (vel_term >>> FRAC_W) +
					longint'(c.feedforward) + (frac_sum >>> FRAC_W);
				if (frac_sum[15:0] >= ROUND_HALF)
					torque++;
				if (torque > TORQUE_MAX || torque < TORQUE_MIN) begin
					r.err = ERR_OVERFLOW;
				end else begin
					mag = (torque < 0) ? -torque : torque;
					lim = c.degraded ? longint'(c.lim_in >> 2) : longint'(c.lim_in);
					r.requested = torque[31:0];
					r.applied = torque[31:0];
					// over the limit: every gain scaled by limit / |torque|
					if (mag > lim) begin
						scale = (lim <<< FRAC_W) / mag;
						r.stiffness = 31'((longint'(c.stiffness) * scale) >>> FRAC_W);
						r.damping = 31'((longint'(c.damping) * scale) >>> FRAC_W);
						r.feedforward = 32'(scale_toward_zero(longint'(c.feedforward), scale));
						r.applied = 32'(scale_toward_zero(torque, scale));
						r.scale = SCALE_W'(scale);
						r.limited = 1'b1;
						if (seen_joints < MASK_W)
							cycle_mask[seen_joints] = 1'b1;
					end
				end
			end
		end
		if (r.err != ERR_OK)
			cycle_error = 1'b1;
		r.mask = cycle_mask;
		// end of control cycle: count activations and start over
		if (c.last_joint) begin
			if (!cycle_error && cycle_mask != '0)
				activations++;
			seen_joints = 0;
			cycle_mask = '0;
			cycle_error = 1'b0;
		end else if (seen_joints < MAX_JOINTS) begin
			seen_joints++;
		end
		r.activations = activations;
		r.cycle_end = c.last_joint;
		return r;
	endfunction

	function automatic bit field_ok(string name, logic [63:0] want, logic [63:0] got);
		if (want === got)
			return 1'b1;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		return 1'b0;
	endfunction

	// watch the three channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		joint_cmd_t    c;
		joint_result_t got;
		joint_result_t want;
		int            bad;
		if (!arst_n) begin
			limiter_on = 1'b1;
			seen_joints = 0;
			cycle_mask = '0;
			activations = '0;
			cycle_error = 1'b0;
			expected_results.delete();
			pending = 0;
		end else begin
			// configuration transaction
			if (cfg.valid && cfg.ready)
				limiter_on = cfg.limiter_enabled;
			// command transaction: queue its expected result
			if (cmd.valid && cmd.ready) begin
				c.lim_in = cmd.joint_torque_limit;
				c.pos_target = cmd.pos_target;
				c.vel_target = cmd.vel_target;
				c.stiffness = cmd.stiffness;
				c.damping = cmd.damping;
				c.feedforward = cmd.ff_torque;
				c.measured_position = cmd.measured_position;
				c.measured_velocity = cmd.measured_velocity;
				c.motor_status = cmd.motor_status;
				c.degraded = cmd.degraded;
				c.last_joint = cmd.last_joint;
				expected_results.insert(expected_results.size(), predict_joint(c));
			end
			// result transaction: compare with the oldest expectation
			if (res.valid && res.ready) begin
				got.stiffness = res.stiffness_out;
				got.damping = res.damping_out;
				got.feedforward = res.feedforward_out;
				got.requested = res.req_torque;
				got.applied = res.applied_torque;
				got.scale = res.gain_scale;
				got.limited = res.torque_limited;
				got.slot = res.joint_slot;
				got.err = itl_err_t'(res.error_code);
				got.mask = res.limited_mask;
				got.activations = res.act_count;
				got.cycle_end = res.cycle_end;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual slot %0d torque %0h",
						$time, got.slot, got.applied);
					fails++;
				end else begin
					want = expected_results.pop_front();
					bad = 0;
					bad += !field_ok("stiffness_out", want.stiffness, got.stiffness);
					bad += !field_ok("damping_out", want.damping, got.damping);
					bad += !field_ok("feedforward_out", want.feedforward, got.feedforward);
					bad += !field_ok("req_torque", want.requested, got.requested);
					bad += !field_ok("applied_torque", want.applied, got.applied);
					bad += !field_ok("gain_scale", want.scale, got.scale);
					bad += !field_ok("torque_limited", want.limited, got.limited);
					bad += !field_ok("joint_slot", want.slot, got.slot);
					bad += !field_ok("error_code", want.err, got.err);
					bad += !field_ok("limited_mask", want.mask, got.mask);
					bad += !field_ok("act_count", want.activations, got.activations);
					bad += !field_ok("cycle_end", want.cycle_end, got.cycle_end);
					fails += bad;
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

### bench/impedance_torque_limiter_core_tb.sv
`timescale 1ns / 1ps
// testbench top: stimulus, idle patterns and verdict for the impedance torque limiter
module impedance_torque_limiter_core_tb;
	import itl_pkg::*;

	localparam int unsigned MAX_JOINTS = 16;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [30:0] lim_in;
		logic [31:0] pos_target;
		logic [31:0] vel_target;
		logic [30:0] stiffness;
		logic [30:0] damping;
		logic [31:0] feedforward;
		logic [31:0] measured_position;
		logic [31:0] measured_velocity;
		logic [7:0]  motor_status;
		logic        degraded;
		logic        last_joint;
	} joint_cmd_t;

	logic clk;
	logic arst_n;
	bit   steady;
	int   fails;
	int   pending;
	int   cycles;
	int   sent;

	itl_cfg_if cfg_ch ();
	itl_cmd_if cmd_ch ();
	itl_res_if res_ch ();

	impedance_torque_limiter_core #(.MAX_JOINTS(MAX_JOINTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	itl_limiter_checker #(.MAX_JOINTS(MAX_JOINTS)) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.cmd(cmd_ch),
		.res(res_ch),
		.fails(fails),
		.pending(pending)
	);

	// clock
	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side stalls at random outside steady stretches
	always @(negedge clk) begin
		res_ch.ready = steady || ($urandom_range(0, 99) >= 30);
	end

	task automatic drive_fields(input joint_cmd_t c);
		cmd_ch.joint_torque_limit = c.lim_in;
		cmd_ch.pos_target = c.pos_target;
		cmd_ch.vel_target = c.vel_target;
		cmd_ch.stiffness = c.stiffness;
		cmd_ch.damping = c.damping;
		cmd_ch.ff_torque = c.feedforward;
		cmd_ch.measured_position = c.measured_position;
		cmd_ch.measured_velocity = c.measured_velocity;
		cmd_ch.motor_status = c.motor_status;
		cmd_ch.degraded = c.degraded;
		cmd_ch.last_joint = c.last_joint;
	endtask

	// one command transaction, with an optional idle gap ahead of it
	task automatic send_joint(input joint_cmd_t c);
		if (!steady && $urandom_range(0, 99) < 30) begin
			cmd_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		drive_fields(c);
		cmd_ch.valid = 1'b1;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	// wait until every expected result has arrived
	task automatic drain();
		cmd_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_limiter(input bit enable);
		drain();
		cfg_ch.limiter_enabled = enable;
		cfg_ch.valid = 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	function automatic joint_cmd_t quiet_joint();
		joint_cmd_t c;
		c = '0;
		c.motor_status = MOTOR_ENABLED;
		return c;
	endfunction

	// random magnitude over a random number of bits, random sign when signed
	function automatic logic [31:0] rand_value(input bit is_signed);
		logic [31:0] v;
		v = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom >> $urandom_range(8, 31));
		if (is_signed && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic joint_cmd_t random_joint(input bit noisy);
		joint_cmd_t c;
		c.lim_in = 31'(rand_value(1'b0));
		c.pos_target = rand_value(1'b1);
		c.vel_target = rand_value(1'b1);
		c.stiffness = 31'(rand_value(1'b0));
		c.damping = 31'(rand_value(1'b0));
		c.feedforward = rand_value(1'b1);
		c.measured_position = rand_value(1'b1);
		c.measured_velocity = rand_value(1'b1);
		if ($urandom_range(0, noisy ? 1 : 19) == 0)
			c.motor_status = 8'($urandom);
		else
			c.motor_status = MOTOR_ENABLED;
		c.degraded = 1'($urandom_range(0, 1));
		c.last_joint = 1'b0;
		return c;
	endfunction

	// control cycles of random length; some too long, some noisy and unterminated
	task automatic run_cycles(input int n);
		int         stop;
		int         len;
		bit         noisy;
		joint_cmd_t c;
		stop = sent + n;
		while (sent < stop) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(MAX_JOINTS + 1, MAX_JOINTS + 4);
			else
				len = $urandom_range(1, MAX_JOINTS);
			noisy = ($urandom_range(0, 7) == 0);
			for (int j = 0; j < len; j++) begin
				c = random_joint(noisy);
				c.last_joint = noisy ? ($urandom_range(0, 3) == 0) : (j == len - 1);
				send_joint(c);
			end
		end
	endtask

	initial begin
		joint_cmd_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		steady = 1'b0;
		sent = 0;
		cycles = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.limiter_enabled = 1'b1;
		cmd_ch.valid = 1'b0;
		drive_fields('0);
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// all zero: no torque, nothing limited
		c = quiet_joint();
		send_joint(c);
		// two radians of error at unit stiffness against a unit limit: halved
		c.stiffness = 31'h10000;
		c.pos_target = 32'h20000;
		c.lim_in = 31'h10000;
		send_joint(c);
		// degraded quarters a 4.0 limit, negative feedforward leaves 1.5
		c.degraded = 1'b1;
		c.lim_in = 31'h40000;
		c.feedforward = -32'sh8000;
		send_joint(c);
		// zero limit against a negative torque scales everything to zero
		c = quiet_joint();
		c.stiffness = 31'h10000;
		c.measured_position = 32'h30000;
		c.feedforward = -32'sh12345;
		send_joint(c);
		// zero limit with zero torque stays unlimited
		c = quiet_joint();
		c.stiffness = '1;
		send_joint(c);
		// half an lsb rounds up
		c = quiet_joint();
		c.stiffness = 31'd1;
		c.pos_target = 32'h8000;
		c.lim_in = '1;
		send_joint(c);
		// negative half an lsb rounds toward plus infinity, closing a limited cycle
		c.pos_target = '0;
		c.measured_position = 32'h8000;
		c.last_joint = 1'b1;
		send_joint(c);
		// largest positive terms overflow
		c = quiet_joint();
		c.lim_in = '1;
		c.stiffness = '1;
		c.damping = '1;
		c.pos_target = 32'h7fffffff;
		c.measured_position = 32'h80000000;
		c.vel_target = 32'h7fffffff;
		c.measured_velocity = 32'h80000000;
		c.feedforward = 32'h7fffffff;
		send_joint(c);
		// and the most negative ones
		c.pos_target = 32'h80000000;
		c.measured_position = 32'h7fffffff;
		c.vel_target = 32'h80000000;
		c.measured_velocity = 32'h7fffffff;
		c.feedforward = 32'h80000000;
		c.degraded = 1'b1;
		send_joint(c);
		// most negative feedforward alone just exceeds the widest limit
		c = quiet_joint();
		c.lim_in = '1;
		c.feedforward = 32'h80000000;
		send_joint(c);
		// largest feedforward equals the widest limit and passes unscaled
		c.feedforward = 32'h7fffffff;
		send_joint(c);
		// motor not enabled
		c.motor_status = 8'd0;
		send_joint(c);
		c.motor_status = 8'd2;
		send_joint(c);
		c.motor_status = 8'hff;
		c.last_joint = 1'b1;
		send_joint(c);
		// damping alone against a quartered limit, a clean limited cycle
		c = quiet_joint();
		c.damping = 31'h8000;
		c.vel_target = -32'sh40000;
		c.lim_in = 31'h30000;
		c.degraded = 1'b1;
		c.last_joint = 1'b1;
		send_joint(c);
		drain();

		// random control cycles across limiter settings
		run_cycles(650);
		set_limiter(1'b0);
		run_cycles(260);
		set_limiter(1'b1);
		run_cycles(300);
		steady = 1'b1;
		run_cycles(300);
		steady = 1'b0;
		run_cycles(100);
		set_limiter(1'b0);
		run_cycles(100);
		set_limiter(1'b1);
		run_cycles(180);

		drain();
		repeat (40) @(negedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
